### hdl/wavhdr_pkg.sv
// ---------------------------------------------------------------------------
// wavhdr_pkg
// Transfer types and constants for the WAV header stream parser.
// ---------------------------------------------------------------------------
package wavhdr_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_FACT = 32'h7463_6166;

    localparam logic [31:0] FMT_WITH_EXTRA = 32'd18;
    localparam logic [31:0] FACT_BODY      = 32'd8;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_BAD_RIFF     = 2'd0;
    localparam logic [1:0] ERR_BAD_WAVE     = 2'd1;
    localparam logic [1:0] ERR_DATA_MISSING = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
    } item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  error_code;
        logic [15:0] audio_format;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic        signed_samples;
        logic [7:0]  data_byte;
        logic        last_data;
    } result_t;

endpackage

### hdl/wav_header_stream_parser.sv
// ---------------------------------------------------------------------------
// wav_header_stream_parser
// Byte-wide RIFF/WAVE header parser: checks tags, captures fmt fields, skips
// other chunks, emits one header transfer or an error, then passes audio bytes through.
// Each result is registered into the result register, or into the skid entry when that is held.
// Throughput: one byte per cycle while the skid entry is empty; the state update for a
// byte is one combinational step into the parser registers.
// A two-entry output stage (result register plus skid) decouples the sides.
// Reset: asynchronous, active low; parser waits for the RIFF tag.
// ---------------------------------------------------------------------------
module wav_header_stream_parser
    import wavhdr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam logic [3:0] PH_RIFF   = 4'd0;
    localparam logic [3:0] PH_WAVE   = 4'd1;
    localparam logic [3:0] PH_FMTSZ  = 4'd2;
    localparam logic [3:0] PH_FORMAT = 4'd3;
    localparam logic [3:0] PH_CHAN   = 4'd4;
    localparam logic [3:0] PH_RATE   = 4'd5;
    localparam logic [3:0] PH_BRATE  = 4'd6;
    localparam logic [3:0] PH_ALIGN  = 4'd7;
    localparam logic [3:0] PH_BITS   = 4'd8;
    localparam logic [3:0] PH_EXTRA  = 4'd9;
    localparam logic [3:0] PH_TAG    = 4'd10;
    localparam logic [3:0] PH_SIZE   = 4'd11;
    localparam logic [3:0] PH_SKIP   = 4'd12;
    localparam logic [3:0] PH_DSIZE  = 4'd13;
    localparam logic [3:0] PH_DATA   = 4'd14;
    localparam logic [3:0] PH_ERR    = 4'd15;

    function automatic logic [3:0] phase_len(input logic [3:0] ph);
        logic [3:0] len;
        len = 4'd0;
        unique case (ph)
            PH_RIFF, PH_RATE, PH_BRATE, PH_TAG, PH_SIZE, PH_DSIZE: len = 4'd4;
            PH_WAVE, PH_FMTSZ:                                  len = 4'd8;
            PH_FORMAT, PH_CHAN, PH_ALIGN, PH_BITS, PH_EXTRA:    len = 4'd2;
            default:                                            len = 4'd0;
        endcase
        return len;
    endfunction

    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] fmt_len_reg, fmt_len_next;
    logic [15:0] format_reg, format_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] brate_reg, brate_next;
    logic [15:0] align_reg, align_next;
    logic [15:0] bits_reg, bits_next;

    logic        out_valid_reg, skid_valid_reg;
    result_t     out_data_reg, skid_data_reg;

    logic        accept, produce, out_take;
    result_t     res;
    logic [31:0] assembled;
    logic [3:0]  pos_inc;
    logic [31:0] skip_dec;

    assign accept     = item_valid & ~skid_valid_reg;
    assign item_stall = skid_valid_reg;
    assign out_take   = out_valid_reg & ~result_stall;
    assign pos_inc    = {1'b0, pos_reg} + 4'd1;
    assign skip_dec   = (skip_reg != 32'd0) ? skip_reg - 32'd1 : skip_reg;
    assign assembled  = (pos_reg[1:0] == 2'd0) ? {24'd0, item.in_byte}
                      : shift_reg | ({24'd0, item.in_byte} << {pos_reg[1:0], 3'b000});

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        shift_next   = shift_reg;
        skip_next    = skip_reg;
        fmt_len_next = fmt_len_reg;
        format_next  = format_reg;
        chan_next    = chan_reg;
        rate_next    = rate_reg;
        brate_next   = brate_reg;
        align_next   = align_reg;
        bits_next    = bits_reg;
        res          = '0;
        produce      = 1'b0;

        if (accept)
        begin
            if (phase_reg <= PH_DSIZE && phase_reg != PH_SKIP)
            begin
                shift_next = assembled;
                if (pos_inc >= phase_len(phase_reg))
                begin
                    pos_next = 3'd0;
                    unique case (phase_reg)
                        PH_RIFF:
                        begin
                            if (assembled != TAG_RIFF)
                            begin
                                res.result_kind = KIND_ERROR;
                                res.error_code  = ERR_BAD_RIFF;
                                produce         = 1'b1;
                                phase_next      = PH_ERR;
                            end
                            else
                            begin
                                phase_next = PH_WAVE;
                            end
                        end
                        PH_WAVE:
                        begin
                            if (assembled != TAG_WAVE)
                            begin
                                res.result_kind = KIND_ERROR;
                                res.error_code  = ERR_BAD_WAVE;
                                produce         = 1'b1;
                                phase_next      = PH_ERR;
                            end
                            else
                            begin
                                phase_next = PH_FMTSZ;
                            end
                        end
                        PH_FMTSZ:
                        begin
                            fmt_len_next = assembled;
                            phase_next   = PH_FORMAT;
                        end
                        PH_FORMAT:
                        begin
                            format_next = assembled[15:0];
                            phase_next  = PH_CHAN;
                        end
                        PH_CHAN:
                        begin
                            chan_next  = assembled[15:0];
                            phase_next = PH_RATE;
                        end
                        PH_RATE:
                        begin
                            rate_next  = assembled;
                            phase_next = PH_BRATE;
                        end
                        PH_BRATE:
                        begin
                            brate_next = assembled;
                            phase_next = PH_ALIGN;
                        end
                        PH_ALIGN:
                        begin
                            align_next = assembled[15:0];
                            phase_next = PH_BITS;
                        end
                        PH_BITS:
                        begin
                            bits_next  = assembled[15:0];
                            phase_next = (fmt_len_reg == FMT_WITH_EXTRA) ? PH_EXTRA : PH_TAG;
                        end
                        PH_EXTRA:
                        begin
                            phase_next = PH_TAG;
                        end
                        PH_TAG:
                        begin
                            if (assembled == TAG_DATA)
                            begin
                                res.result_kind     = KIND_HEADER;
                                res.audio_format    = format_reg;
                                res.channels        = chan_reg;
                                res.sample_rate     = rate_reg;
                                res.byte_rate       = brate_reg;
                                res.block_align     = align_reg;
                                res.bits_per_sample = bits_reg;
                                res.signed_samples  = (bits_reg > 16'd8);
                                produce             = 1'b1;
                                phase_next          = PH_DSIZE;
                            end
                            else if (assembled == TAG_FACT)
                            begin
                                skip_next  = FACT_BODY;
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                phase_next = PH_SIZE;
                            end
                        end
                        PH_SIZE:
                        begin
                            skip_next  = assembled;
                            phase_next = (assembled == 32'd0) ? PH_TAG : PH_SKIP;
                        end
                        default:
                        begin
                            phase_next = PH_DATA;
                        end
                    endcase
                end
                else
                begin
                    pos_next = pos_inc[2:0];
                end
            end
            else if (phase_reg == PH_SKIP)
            begin
                skip_next = skip_dec;
                if (skip_dec == 32'd0)
                begin
                    phase_next = PH_TAG;
                    pos_next   = 3'd0;
                end
            end
            else if (phase_reg == PH_DATA)
            begin
                res.result_kind = KIND_DATA;
                res.data_byte   = item.in_byte;
                res.last_data   = item.end_of_file;
                produce         = 1'b1;
            end

            if (item.end_of_file)
            begin
                if (!produce && phase_reg <= PH_SKIP)
                begin
                    res             = '0;
                    res.result_kind = KIND_ERROR;
                    res.error_code  = ERR_DATA_MISSING;
                    produce         = 1'b1;
                end
                phase_next = PH_RIFF;
                pos_next   = 3'd0;
                shift_next = 32'd0;
                skip_next  = 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_RIFF;
            pos_reg     <= 3'd0;
            shift_reg   <= 32'd0;
            skip_reg    <= 32'd0;
            fmt_len_reg <= 32'd0;
            format_reg  <= 16'd0;
            chan_reg    <= 16'd0;
            rate_reg    <= 32'd0;
            brate_reg   <= 32'd0;
            align_reg   <= 16'd0;
            bits_reg    <= 16'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            shift_reg   <= shift_next;
            skip_reg    <= skip_next;
            fmt_len_reg <= fmt_len_next;
            format_reg  <= format_next;
            chan_reg    <= chan_next;
            rate_reg    <= rate_next;
            brate_reg   <= brate_next;
            align_reg   <= align_next;
            bits_reg    <= bits_next;
        end
    end

    // result register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_reg <= produce;
        end
        else if (produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            out_data_reg <= res;
        end
        else if (produce)
        begin
            skid_data_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty result register");

    a_data_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_DATA) |=> out_valid_reg)
        else $error("audio byte transfer lost");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> (skip_reg != 32'd0))
        else $error("skip phase with zero count");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERR && !(accept && item.end_of_file)) |=> (phase_reg == PH_ERR))
        else $error("left error phase without end of file");

endmodule

### tb/wav_header_stream_parser_test.sv
// ---------------------------------------------------------------------------
// wav_header_stream_parser_test
// Self-checking bench for the byte-wide WAV header parser. A short table of
// tag errors and early ends is driven first, then randomly composed files:
// fmt size variants, fact and foreign chunks, truncations and noise. Every
// accepted byte runs through an in-bench parser and each result transfer is
// checked field by field. Both sides idle at random and the result side
// holds off once for a long stretch so that the parser backs up.
// ---------------------------------------------------------------------------
module wav_header_stream_parser_test
    import wavhdr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int ITEM_TARGET  = 850;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int NUM_DIRECTED = 23;

    typedef enum logic [3:0] {
        P_RIFF, P_WAVE, P_FMT_SIZE, P_FORMAT, P_CHANNELS, P_RATE, P_BYTE_RATE,
        P_ALIGN, P_BITS, P_EXTRA, P_TAG, P_CHUNK_SIZE, P_SKIP, P_DATA_SIZE,
        P_DATA, P_HALTED
    } parse_phase_e;

    typedef enum logic [1:0] {
        CHECK_MODEL, CHECK_NONE, CHECK_ERROR
    } check_e;

    typedef struct packed {
        item_t      it;
        check_e     chk;
        logic [1:0] err;
    } vector_t;

    localparam vector_t DIRECTED [NUM_DIRECTED] = '{
        '{'{8'h00, 1'b1}, CHECK_ERROR, ERR_DATA_MISSING},
        '{'{8'h52, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'h49, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'h46, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'h58, 1'b0}, CHECK_ERROR, ERR_BAD_RIFF},
        '{'{8'hFF, 1'b1}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'h52, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'h49, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'h46, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'h46, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'hFF, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'hFF, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'hFF, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'hFF, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'h57, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'h41, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'h56, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'h58, 1'b0}, CHECK_ERROR, ERR_BAD_WAVE},
        '{'{8'h00, 1'b1}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'h52, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'h49, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'h46, 1'b0}, CHECK_NONE,  ERR_BAD_RIFF},
        '{'{8'h46, 1'b1}, CHECK_ERROR, ERR_DATA_MISSING}
    };

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // in-bench parser state
    parse_phase_e phase         = P_RIFF;
    logic [2:0]   byte_pos      = '0;
    logic [31:0]  shift_word    = '0;
    logic [31:0]  bytes_to_skip = '0;
    logic [31:0]  fmt_size      = '0;
    logic [15:0]  fmt_format    = '0;
    logic [15:0]  fmt_channels  = '0;
    logic [31:0]  fmt_rate      = '0;
    logic [31:0]  fmt_byte_rate = '0;
    logic [15:0]  fmt_align     = '0;
    logic [15:0]  fmt_bits      = '0;

    result_t    due_outputs[$];
    logic [7:0] file_bytes[$];
    int         items_sent   = 0;
    int         mismatches   = 0;
    int         cycle_count  = 0;
    bit         sender_quiet = 1'b0;
    logic       hold_off     = 1'b0;

    wav_header_stream_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic bit parse_byte(input item_t it, output result_t res);
        parse_phase_e ph;
        int           flen;
        int           pos;
        bit           hit;
        ph  = phase;
        pos = int'(byte_pos);
        hit = 1'b0;
        res = '0;
        if (ph == P_SKIP)
        begin
            if (bytes_to_skip != 0)
                bytes_to_skip = bytes_to_skip - 1;
            if (bytes_to_skip == 0)
            begin
                phase    = P_TAG;
                byte_pos = '0;
            end
        end
        else if (ph == P_DATA)
        begin
            res.result_kind = KIND_DATA;
            res.data_byte   = it.in_byte;
            res.last_data   = it.end_of_file;
            hit = 1'b1;
        end
        else if (ph != P_HALTED)
        begin
            case (ph)
                P_RIFF, P_RATE, P_BYTE_RATE, P_TAG, P_CHUNK_SIZE, P_DATA_SIZE: flen = 4;
                P_WAVE, P_FMT_SIZE: flen = 8;
                default: flen = 2;
            endcase
            // size word and tag share one field; only the last four bytes count
            if (pos[1:0] == 2'd0)
                shift_word = {24'd0, it.in_byte};
            else
                shift_word |= {24'd0, it.in_byte} << (8 * pos[1:0]);
            if (pos + 1 >= flen)
            begin
                byte_pos = '0;
                case (ph)
                    P_RIFF:
                    begin
                        if (shift_word != TAG_RIFF)
                        begin
                            res.result_kind = KIND_ERROR;
                            res.error_code  = ERR_BAD_RIFF;
                            phase = P_HALTED;
                            hit   = 1'b1;
                        end
                        else
                            phase = P_WAVE;
                    end
                    P_WAVE:
                    begin
                        if (shift_word != TAG_WAVE)
                        begin
                            res.result_kind = KIND_ERROR;
                            res.error_code  = ERR_BAD_WAVE;
                            phase = P_HALTED;
                            hit   = 1'b1;
                        end
                        else
                            phase = P_FMT_SIZE;
                    end
                    P_FMT_SIZE:
                    begin
                        fmt_size = shift_word;
                        phase    = P_FORMAT;
                    end
                    P_FORMAT:
                    begin
                        fmt_format = shift_word[15:0];
                        phase      = P_CHANNELS;
                    end
                    P_CHANNELS:
                    begin
                        fmt_channels = shift_word[15:0];
                        phase        = P_RATE;
                    end
                    P_RATE:
                    begin
                        fmt_rate = shift_word;
                        phase    = P_BYTE_RATE;
                    end
                    P_BYTE_RATE:
                    begin
                        fmt_byte_rate = shift_word;
                        phase         = P_ALIGN;
                    end
                    P_ALIGN:
                    begin
                        fmt_align = shift_word[15:0];
                        phase     = P_BITS;
                    end
                    P_BITS:
                    begin
                        fmt_bits = shift_word[15:0];
                        phase    = (fmt_size == FMT_WITH_EXTRA) ? P_EXTRA : P_TAG;
                    end
                    P_EXTRA:
                        phase = P_TAG;
                    P_TAG:
                    begin
                        if (shift_word == TAG_DATA)
                        begin
                            res.result_kind     = KIND_HEADER;
                            res.audio_format    = fmt_format;
                            res.channels        = fmt_channels;
                            res.sample_rate     = fmt_rate;
                            res.byte_rate       = fmt_byte_rate;
                            res.block_align     = fmt_align;
                            res.bits_per_sample = fmt_bits;
                            res.signed_samples  = (fmt_bits > 16'd8);
                            phase = P_DATA_SIZE;
                            hit   = 1'b1;
                        end
                        else if (shift_word == TAG_FACT)
                        begin
                            bytes_to_skip = FACT_BODY;
                            phase         = P_SKIP;
                        end
                        else
                            phase = P_CHUNK_SIZE;
                    end
                    P_CHUNK_SIZE:
                    begin
                        bytes_to_skip = shift_word;
                        phase         = (shift_word == 0) ? P_TAG : P_SKIP;
                    end
                    default:
                        phase = P_DATA;
                endcase
            end
            else
                byte_pos = 3'(pos + 1);
        end
        if (it.end_of_file)
        begin
            if (!hit && ph <= P_SKIP)
            begin
                res.result_kind = KIND_ERROR;
                res.error_code  = ERR_DATA_MISSING;
                hit = 1'b1;
            end
            phase         = P_RIFF;
            byte_pos      = '0;
            shift_word    = '0;
            bytes_to_skip = '0;
        end
        return hit;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_le(input logic [31:0] w, input int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(w[8*i +: 8]);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic transfer_byte(input item_t it, input check_e chk, input logic [1:0] err);
        result_t res;
        result_t typed;
        bit      hit;
        int      gap;
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        items_sent++;
        hit = parse_byte(it, res);
        if (chk == CHECK_MODEL && hit)
            due_outputs.push_back(res);
        else if (chk == CHECK_ERROR)
        begin
            typed             = '0;
            typed.result_kind = KIND_ERROR;
            typed.error_code  = err;
            due_outputs.push_back(typed);
        end
        gap = (sender_quiet || hold_off) ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // byte source
    initial
    begin
        item_t       x;
        int          r;
        int          cut;
        int          data_tag_end;
        logic [31:0] w;
        logic [31:0] fsize;
        logic [31:0] ctag;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            transfer_byte(DIRECTED[i].it, DIRECTED[i].chk, DIRECTED[i].err);

        while (items_sent < NUM_DIRECTED + ITEM_TARGET)
        begin
            file_bytes   = {};
            data_tag_end = 0;
            sender_quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                repeat ($urandom_range(1, 10)) file_bytes.push_back(8'($urandom));
            end
            else
            begin
                w = TAG_RIFF;
                if (r < 14)
                    w ^= 32'd1 << $urandom_range(0, 31);
                push_le(w, 4);
                push_le($urandom, 4);
                w = TAG_WAVE;
                if (r >= 14 && r < 20)
                    w ^= 32'd1 << $urandom_range(0, 31);
                push_le(w, 4);
                push_le($urandom, 4);
                case ($urandom_range(0, 3))
                    0, 1: fsize = 32'd16;
                    2: fsize = FMT_WITH_EXTRA;
                    default: fsize = pick_value();
                endcase
                push_le(fsize, 4);
                push_le(pick_value(), 2);
                push_le(pick_value(), 2);
                push_le(pick_value(), 4);
                push_le(pick_value(), 4);
                push_le(pick_value(), 2);
                push_le($urandom_range(0, 1) ? 32'($urandom_range(0, 24)) : pick_value(), 2);
                if (fsize == FMT_WITH_EXTRA)
                    push_le($urandom, 2);
                repeat ($urandom_range(0, 3))
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        push_le(TAG_FACT, 4);
                        push_le($urandom, 4);
                        push_le($urandom, 4);
                    end
                    else
                    begin
                        ctag = $urandom;
                        if (ctag == TAG_DATA || ctag == TAG_FACT)
                            ctag = ~ctag;
                        push_le(ctag, 4);
                        w = $urandom_range(0, 6);
                        push_le(w, 4);
                        repeat (w) file_bytes.push_back(8'($urandom));
                    end
                end
                if ($urandom_range(0, 19) == 0)
                begin
                    // oversized foreign chunk, file ends inside it
                    push_le(~TAG_DATA, 4);
                    push_le(32'hFFFF_FFFF, 4);
                    repeat ($urandom_range(1, 8)) file_bytes.push_back(8'($urandom));
                end
                else
                begin
                    push_le(TAG_DATA, 4);
                    data_tag_end = file_bytes.size();
                    push_le($urandom, 4);
                    repeat ($urandom_range(0, 40)) file_bytes.push_back(8'($urandom));
                end
            end
            r = $urandom_range(0, 9);
            if (r < 2)
            begin
                cut = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > cut)
                    void'(file_bytes.pop_back());
            end
            else if (r == 2 && data_tag_end > 0)
            begin
                while (file_bytes.size() > data_tag_end)
                    void'(file_bytes.pop_back());
            end
            foreach (file_bytes[i])
            begin
                x.in_byte     = file_bytes[i];
                x.end_of_file = (i == file_bytes.size() - 1);
                transfer_byte(x, CHECK_MODEL, ERR_BAD_RIFF);
            end
        end
        item_valid <= 1'b0;

        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // long hold-off on the result side
    initial
    begin
        while (items_sent < HOLD_AFTER)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // result sink and checker
    initial
    begin
        int      n;
        int      served;
        bit      rx_quiet;
        result_t want;
        served   = 0;
        rx_quiet = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (served % 32 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            n = rx_quiet ? 0 : $urandom_range(0, 16);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            if (hold_off)
            begin
                result_stall <= 1'b1;
                while (hold_off)
                    @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            served++;
            if (due_outputs.size() == 0)
                report_mismatch($sformatf("transfer of kind %0d with nothing due",
                                          result.result_kind));
            else
            begin
                want = due_outputs.pop_front();
                compare_field("result_kind", 32'(result.result_kind),
                              32'(want.result_kind));
                compare_field("error_code", 32'(result.error_code),
                              32'(want.error_code));
                compare_field("audio_format", 32'(result.audio_format),
                              32'(want.audio_format));
                compare_field("channels", 32'(result.channels), 32'(want.channels));
                compare_field("sample_rate", result.sample_rate, want.sample_rate);
                compare_field("byte_rate", result.byte_rate, want.byte_rate);
                compare_field("block_align", 32'(result.block_align),
                              32'(want.block_align));
                compare_field("bits_per_sample", 32'(result.bits_per_sample),
                              32'(want.bits_per_sample));
                compare_field("signed_samples", 32'(result.signed_samples),
                              32'(want.signed_samples));
                compare_field("data_byte", 32'(result.data_byte), 32'(want.data_byte));
                compare_field("last_data", 32'(result.last_data), 32'(want.last_data));
            end
        end
    end

endmodule

### wav_header_stream_parser.f
hdl/wavhdr_pkg.sv
hdl/wav_header_stream_parser.sv
tb/wav_header_stream_parser_test.sv
